>>> sv/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg: shared definitions for the client RSSI table
// Field widths, action and status codes, and stream bus widths.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int MAC_W  = 48;
    localparam int RSSI_W = 8;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;

    typedef logic [ACT_W-1:0]         action_t;
    typedef logic [STAT_W-1:0]        status_t;
    typedef logic [MAC_W-1:0]         mac_t;
    typedef logic signed [RSSI_W-1:0] rssi_t;

    localparam action_t ACT_ADD    = 2'd0;
    localparam action_t ACT_REMOVE = 2'd1;
    localparam action_t ACT_UPDATE = 2'd2;
    localparam action_t ACT_LOCATE = 2'd3;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_NOT_FOUND = 2'd1;
    localparam status_t STAT_FULL      = 2'd2;

    // Input transfer: action, client_mac, ap_mac, rssi (106 bits, padded to 112).
    localparam int S_TDATA_W = 112;
    // Result transfer: status, found_ap_mac, last_rssi, mean_rssi (66 bits, padded to 72).
    localparam int M_TDATA_W = 72;

    localparam int M_AMAC_LSB = STAT_W;
    localparam int M_LAST_LSB = M_AMAC_LSB + MAC_W;
    localparam int M_MEAN_LSB = M_LAST_LSB + RSSI_W;
    localparam int M_USED_W   = M_MEAN_LSB + RSSI_W;

endpackage

>>> sv/crt_ram.sv
// ----------------------------------------------------------------------------
// crt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/crt_mean_unit.sv
// ----------------------------------------------------------------------------
// crt_mean_unit: iterative trimmed mean
// Walks the samples one per cycle for sum, minimum and maximum, then trims the
// sum and divides it by the sample count less two with a reciprocal multiply.
// ----------------------------------------------------------------------------
module crt_mean_unit #(
    parameter int HISTORY_LEN = 5
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [crt_pkg::RSSI_W*HISTORY_LEN-1:0] hist,
    output logic                                   done,
    output crt_pkg::rssi_t                         mean
);

    localparam int KW      = $clog2(HISTORY_LEN);
    localparam int SW      = crt_pkg::RSSI_W + $clog2(HISTORY_LEN) + 1;
    localparam int DIVISOR = HISTORY_LEN - 2;
    // The scale leaves the rounding error of the reciprocal below one quotient
    // step for every trimmed magnitude up to 128 times the divisor.
    localparam int SH      = crt_pkg::RSSI_W + 2 * $clog2(DIVISOR) + 1;
    localparam int RECIP   = (2**SH + DIVISOR - 1) / DIVISOR;
    localparam int PW      = SW + SH;

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_ACC  = 2'd1;
    localparam logic [1:0] M_TRIM = 2'd2;
    localparam logic [1:0] M_DIV  = 2'd3;

    logic [1:0]           mstate_reg, mstate_next;
    logic [KW-1:0]        k_reg, k_next;
    logic                 done_reg, done_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [SW-1:0] lo_reg, lo_next;
    logic signed [SW-1:0] hi_reg, hi_next;
    logic                 neg_reg, neg_next;
    logic [SW-1:0]        mag_reg, mag_next;
    crt_pkg::rssi_t       mean_reg, mean_next;

    logic [crt_pkg::RSSI_W-1:0] sample;
    logic signed [SW-1:0]       v;
    logic signed [SW-1:0]       trimmed;
    logic [PW-1:0]              prod;
    logic [crt_pkg::RSSI_W-1:0] quot;

    assign sample  = hist[k_reg*crt_pkg::RSSI_W +: crt_pkg::RSSI_W];
    assign v       = {{(SW-crt_pkg::RSSI_W){sample[crt_pkg::RSSI_W-1]}}, sample};
    assign trimmed = sum_reg - lo_reg - hi_reg;
    assign prod    = PW'(mag_reg) * PW'(RECIP);
    assign quot    = prod[SH +: crt_pkg::RSSI_W];

    always_comb begin
        mstate_next = mstate_reg;
        k_next      = k_reg;
        done_next   = 1'b0;
        sum_next    = sum_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        mean_next   = mean_reg;
        case (mstate_reg)
            M_IDLE: begin
                if (start) begin
                    k_next      = '0;
                    mstate_next = M_ACC;
                end
            end
            M_ACC: begin
                if (k_reg == '0) begin
                    sum_next = v;
                    lo_next  = v;
                    hi_next  = v;
                end else begin
                    sum_next = sum_reg + v;
                    lo_next  = (v < lo_reg) ? v : lo_reg;
                    hi_next  = (v > hi_reg) ? v : hi_reg;
                end
                k_next = k_reg + KW'(1);
                if (k_reg == KW'(HISTORY_LEN - 1)) begin
                    mstate_next = M_TRIM;
                end
            end
            M_TRIM: begin
                // Divide the magnitude and restore the sign, which truncates toward zero.
                neg_next    = trimmed[SW-1];
                mag_next    = trimmed[SW-1] ? SW'(-trimmed) : SW'(trimmed);
                mstate_next = M_DIV;
            end
            M_DIV: begin
                mean_next   = neg_reg ? crt_pkg::rssi_t'(-quot) : crt_pkg::rssi_t'(quot);
                done_next   = 1'b1;
                mstate_next = M_IDLE;
            end
            default: begin
                mstate_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mstate_reg <= M_IDLE;
            done_reg   <= 1'b0;
        end else begin
            mstate_reg <= mstate_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        sum_reg  <= sum_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        mean_reg <= mean_next;
    end

    assign done = done_reg;
    assign mean = mean_reg;

endmodule

>>> sv/client_rssi_table.sv
// Each input is answered after one scan pass for locate and for a miss or a full table,
// after two scan passes for add and remove, and after one pass and the trimmed mean for update.
// Throughput: one item at a time, the next input transfer in the cycle after the result
// transfer; the RAM's single read port scans one slot per cycle, the mean unit one sample.
// Reset: synchronous; afterwards a clearing pass writes every slot to zero to empty the
// table, and no input transfer is taken until it ends.
// ----------------------------------------------------------------------------
// client_rssi_table: wireless client table keyed by client MAC
// Add, remove, update and locate over a table held in one RAM, scanned slot by
// slot under a small sequencer, with a single unit for the trimmed RSSI mean of updates.
// ----------------------------------------------------------------------------
module client_rssi_table #(
    parameter int MAX_CLIENTS = 64,
    parameter int HISTORY_LEN = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata fields from bit 0: action[2], client_mac[48], ap_mac[48], rssi[8], zero pad
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [crt_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata fields from bit 0: status[2], found_ap_mac[48], last_rssi[8],
    // mean_rssi[8], zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [crt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int MW = crt_pkg::MAC_W;
    localparam int RS = crt_pkg::RSSI_W;
    localparam int IW = $clog2(MAX_CLIENTS);
    localparam int AW = IW;
    localparam int RW = $clog2(HISTORY_LEN);
    localparam int HW = RS * HISTORY_LEN;

    // Entry word layout from bit 0: mean, ring index, history, last rssi,
    // ap mac, client mac, age, valid.
    localparam int O_MEAN  = 0;
    localparam int O_RING  = O_MEAN + RS;
    localparam int O_HIST  = O_RING + RW;
    localparam int O_LAST  = O_HIST + HW;
    localparam int O_AMAC  = O_LAST + RS;
    localparam int O_CMAC  = O_AMAC + MW;
    localparam int O_AGE   = O_CMAC + MW;
    localparam int O_VALID = O_AGE + AW;
    localparam int EW      = O_VALID + 1;

    localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_CLIENTS - 1);
    localparam logic [RW-1:0] LAST_RING = RW'(HISTORY_LEN - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN1  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SCAN2  = 3'd4;
    localparam logic [2:0] S_MEAN   = 3'd5;
    localparam logic [2:0] S_WRITE  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]      state_reg, state_next;
    logic [IW-1:0]   addr_reg, addr_next;
    logic            iss_reg, iss_next;
    logic            rv_reg, rv_next;
    logic [IW-1:0]   ridx_reg, ridx_next;

    crt_pkg::action_t act_reg, act_next;
    crt_pkg::mac_t    cmac_reg, cmac_next;
    crt_pkg::mac_t    amac_reg, amac_next;
    crt_pkg::rssi_t   rssi_reg, rssi_next;

    logic            found_reg, found_next;
    logic [IW-1:0]   slot_reg, slot_next;
    logic [AW-1:0]   bage_reg, bage_next;
    crt_pkg::mac_t   e_amac_reg, e_amac_next;
    crt_pkg::rssi_t  e_last_reg, e_last_next;
    logic [HW-1:0]   e_hist_reg, e_hist_next;
    logic [RW-1:0]   e_ring_reg, e_ring_next;
    crt_pkg::rssi_t  e_mean_reg, e_mean_next;

    crt_pkg::status_t st_reg, st_next;
    crt_pkg::mac_t    o_amac_reg, o_amac_next;
    crt_pkg::rssi_t   o_last_reg, o_last_next;
    crt_pkg::rssi_t   o_mean_reg, o_mean_next;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic [EW-1:0]   ram_rdata;

    logic            rd_valid;
    logic [AW-1:0]   rd_age;
    crt_pkg::mac_t   rd_cmac;
    logic            mean_start;
    logic            mean_done;
    crt_pkg::rssi_t  mean_val;
    logic [RW-1:0]   ring_new;
    logic [EW-1:0]   wd;

    assign rd_valid = ram_rdata[O_VALID];
    assign rd_age   = ram_rdata[O_AGE +: AW];
    assign rd_cmac  = ram_rdata[O_CMAC +: MW];
    assign ring_new = (e_ring_reg == LAST_RING) ? '0 : e_ring_reg + RW'(1);

    crt_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_CLIENTS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    crt_mean_unit #(
        .HISTORY_LEN(HISTORY_LEN)
    ) u_mean (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mean_start),
        .hist   (e_hist_reg),
        .done   (mean_done),
        .mean   (mean_val)
    );

    always_comb begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        iss_next    = iss_reg;
        rv_next     = 1'b0;
        ridx_next   = ridx_reg;
        act_next    = act_reg;
        cmac_next   = cmac_reg;
        amac_next   = amac_reg;
        rssi_next   = rssi_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        bage_next   = bage_reg;
        e_amac_next = e_amac_reg;
        e_last_next = e_last_reg;
        e_hist_next = e_hist_reg;
        e_ring_next = e_ring_reg;
        e_mean_next = e_mean_reg;
        st_next     = st_reg;
        o_amac_next = o_amac_reg;
        o_last_next = o_last_reg;
        o_mean_next = o_mean_reg;
        ram_we      = 1'b0;
        ram_waddr   = ridx_reg;
        ram_wdata   = ram_rdata;
        mean_start  = 1'b0;
        wd          = ram_rdata;

        // Read issue for both scan passes; the read data returns in the following cycle.
        if (state_reg == S_SCAN1 || state_reg == S_SCAN2) begin
            rv_next   = iss_reg;
            ridx_next = addr_reg;
            if (iss_reg) begin
                addr_next = addr_reg + IW'(1);
                if (addr_reg == LAST_SLOT) begin
                    iss_next = 1'b0;
                end
            end
        end

        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = '0;
                addr_next = addr_reg + IW'(1);
                if (addr_reg == LAST_SLOT) begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tdata[1:0];
                    cmac_next  = s_tdata[2 +: MW];
                    amac_next  = s_tdata[2 + MW +: MW];
                    rssi_next  = s_tdata[2 + 2*MW +: RS];
                    found_next = 1'b0;
                    addr_next  = '0;
                    iss_next   = 1'b1;
                    state_next = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (rv_reg) begin
                    if (act_reg == crt_pkg::ACT_ADD) begin
                        if (!found_reg && !rd_valid) begin
                            found_next = 1'b1;
                            slot_next  = ridx_reg;
                        end
                    end else if (rd_valid && rd_cmac == cmac_reg &&
                                 (!found_reg || rd_age < bage_reg)) begin
                        // Valid ages are distinct, so the smallest marks the newest entry.
                        found_next  = 1'b1;
                        slot_next   = ridx_reg;
                        bage_next   = rd_age;
                        e_amac_next = ram_rdata[O_AMAC +: MW];
                        e_last_next = ram_rdata[O_LAST +: RS];
                        e_hist_next = ram_rdata[O_HIST +: HW];
                        e_ring_next = ram_rdata[O_RING +: RW];
                        e_mean_next = ram_rdata[O_MEAN +: RS];
                    end
                    if (ridx_reg == LAST_SLOT) begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                st_next     = crt_pkg::STAT_OK;
                o_amac_next = e_amac_reg;
                o_last_next = e_last_reg;
                o_mean_next = e_mean_reg;
                addr_next   = '0;
                iss_next    = 1'b1;
                if (!found_reg) begin
                    st_next     = (act_reg == crt_pkg::ACT_ADD) ? crt_pkg::STAT_FULL
                                                                : crt_pkg::STAT_NOT_FOUND;
                    o_amac_next = '0;
                    o_last_next = '0;
                    o_mean_next = '0;
                    state_next  = S_OUT;
                end else begin
                    case (act_reg)
                        crt_pkg::ACT_ADD:    state_next = S_SCAN2;
                        crt_pkg::ACT_REMOVE: state_next = S_SCAN2;
                        crt_pkg::ACT_UPDATE: begin
                            e_ring_next                    = ring_new;
                            e_hist_next[ring_new*RS +: RS] = rssi_reg;
                            e_last_next                    = rssi_reg;
                            e_amac_next                    = amac_reg;
                            mean_start                     = 1'b1;
                            state_next                     = S_MEAN;
                        end
                        crt_pkg::ACT_LOCATE: state_next = S_OUT;
                        default:             state_next = S_OUT;
                    endcase
                end
            end
            S_SCAN2: begin
                // Second pass rewrites each slot: the target entry, and the ages of the others.
                if (rv_reg) begin
                    if (act_reg == crt_pkg::ACT_ADD) begin
                        if (ridx_reg == slot_reg) begin
                            wd = {1'b1, {AW{1'b0}}, cmac_reg, amac_reg, rssi_reg,
                                  {(HW-RS){1'b0}}, rssi_reg, {RW{1'b0}}, {RS{1'b0}}};
                        end else if (rd_valid) begin
                            wd[O_AGE +: AW] = rd_age + AW'(1);
                        end
                    end else begin
                        if (ridx_reg == slot_reg) begin
                            wd[O_VALID]     = 1'b0;
                            wd[O_AGE +: AW] = '0;
                        end else if (rd_valid && rd_age > bage_reg) begin
                            wd[O_AGE +: AW] = rd_age - AW'(1);
                        end
                    end
                    ram_we    = 1'b1;
                    ram_waddr = ridx_reg;
                    ram_wdata = wd;
                    if (ridx_reg == LAST_SLOT) begin
                        if (act_reg == crt_pkg::ACT_ADD) begin
                            o_amac_next = amac_reg;
                            o_last_next = rssi_reg;
                            o_mean_next = '0;
                        end
                        state_next = S_OUT;
                    end
                end
            end
            S_MEAN: begin
                if (mean_done) begin
                    e_mean_next = mean_val;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE: begin
                ram_we      = 1'b1;
                ram_waddr   = slot_reg;
                ram_wdata   = {1'b1, bage_reg, cmac_reg, e_amac_reg, e_last_reg,
                               e_hist_reg, e_ring_reg, e_mean_reg};
                o_amac_next = e_amac_reg;
                o_last_next = e_last_reg;
                o_mean_next = e_mean_reg;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            iss_reg   <= 1'b0;
            rv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            iss_reg   <= iss_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge aclk) begin
        ridx_reg   <= ridx_next;
        act_reg    <= act_next;
        cmac_reg   <= cmac_next;
        amac_reg   <= amac_next;
        rssi_reg   <= rssi_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        bage_reg   <= bage_next;
        e_amac_reg <= e_amac_next;
        e_last_reg <= e_last_next;
        e_hist_reg <= e_hist_next;
        e_ring_reg <= e_ring_next;
        e_mean_reg <= e_mean_next;
        st_reg     <= st_next;
        o_amac_reg <= o_amac_next;
        o_last_reg <= o_last_next;
        o_mean_reg <= o_mean_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {{(crt_pkg::M_TDATA_W - crt_pkg::M_USED_W){1'b0}},
                       o_mean_reg, o_last_reg, o_amac_reg, st_reg};

endmodule

>>> sv/crt_checker.sv
// ----------------------------------------------------------------------------
// crt_checker: port-level checks for the client RSSI table
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module crt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [crt_pkg::M_TDATA_W-1:0] m_tdata
);

    crt_pkg::status_t status;
    assign status = m_tdata[crt_pkg::STAT_W-1:0];

    // Only one item is in flight, so input and result are never offered together.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // After an input transfer the block is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after an input transfer");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (status == crt_pkg::STAT_OK || status == crt_pkg::STAT_NOT_FOUND ||
                      status == crt_pkg::STAT_FULL))
        else $error("undefined status code");

    // A failed action reports no entry contents.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status != crt_pkg::STAT_OK) |->
            (m_tdata[crt_pkg::M_USED_W-1:crt_pkg::M_AMAC_LSB] == '0))
        else $error("failed result carries nonzero fields");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind client_rssi_table crt_checker u_crt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
